FILE: rtl/trsi_pkg.sv
// ----------------------------------------------------------------------------
// trsi_pkg
// Shared constants, types and the restoring division step used by the
// tile repeat source index pipeline.
// ----------------------------------------------------------------------------
package trsi_pkg;

   localparam int MAX_DIMS      = 4;
   localparam int IdxW          = 32;
   localparam int ExtW          = 16;
   localparam int CfgW          = 64;
   localparam int CsrIdxW       = 3;
   localparam int DimsW         = 3;
   localparam int BitsPerStage  = 2;
   localparam int DivStages     = IdxW / BitsPerStage;

   // Register indexes of the configuration port.
   localparam logic [CsrIdxW-1:0] CsrActiveDims = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrStride0    = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrStride1    = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrStride2    = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrStride3    = 3'd4;
   localparam logic [CsrIdxW-1:0] CsrExtents    = 3'd5;

   localparam logic [DimsW-1:0] ActiveDimsReset = 3'd1;
   localparam logic [CfgW-1:0]  StrideReset     = 64'h0000_0001_0000_0000;
   localparam logic [CfgW-1:0]  ExtentsReset    = 64'h0001_0001_0001_0001;

   typedef struct packed {
      logic [IdxW-1:0] rem;
      logic            q;
   } div_step_type;

   // One step of restoring division: shift in one dividend bit, subtract
   // the divisor when it fits.
   function automatic div_step_type div_step(input logic [IdxW-1:0] rem,
                                             input logic            nbit,
                                             input logic [IdxW-1:0] divisor);
      logic [IdxW:0] t;
      logic [IdxW:0] diff;
      div_step_type  res;
      t    = {rem, nbit};
      diff = t - {1'b0, divisor};
      if (t >= {1'b0, divisor}) begin
         res.rem = diff[IdxW-1:0];
         res.q   = 1'b1;
      end else begin
         res.rem = t[IdxW-1:0];
         res.q   = 1'b0;
      end
      return res;
   endfunction

endpackage

FILE: rtl/trsi_divider.sv
// ----------------------------------------------------------------------------
// trsi_divider
// Pipelined restoring divider, two quotient bits per stage, sideband per beat.
// The user must hold the divisor static while items flow; it is not checked.
// ----------------------------------------------------------------------------
module trsi_divider #(
   parameter int SB_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [trsi_pkg::IdxW-1:0]  in_dividend,
   input  logic [trsi_pkg::IdxW-1:0]  in_divisor,
   input  logic [SB_W-1:0]            in_sb,
   output logic                       out_valid,
   output logic [trsi_pkg::IdxW-1:0]  out_quot,
   output logic [trsi_pkg::IdxW-1:0]  out_rem,
   output logic [SB_W-1:0]            out_sb
);

   localparam int N = trsi_pkg::DivStages;

   logic                      v_w  [N+1];
   logic [trsi_pkg::IdxW-1:0] nq_w [N+1];
   logic [trsi_pkg::IdxW-1:0] r_w  [N+1];
   logic [SB_W-1:0]           sb_w [N+1];

   assign v_w[0]  = in_valid;
   assign nq_w[0] = in_dividend;
   assign r_w[0]  = '0;
   assign sb_w[0] = in_sb;

   for (genvar s = 0; s < N; s++) begin : g_stage
      logic                      valid_ff;
      logic [trsi_pkg::IdxW-1:0] nq_ff, nq_in;
      logic [trsi_pkg::IdxW-1:0] r_ff, r_in;
      logic [SB_W-1:0]           sb_ff;

      // The dividend shifts out at the top while quotient bits enter below.
      always_comb begin
         trsi_pkg::div_step_type st;
         nq_in = nq_w[s];
         r_in  = r_w[s];
         for (int k = 0; k < trsi_pkg::BitsPerStage; k++) begin
            st    = trsi_pkg::div_step(r_in, nq_in[trsi_pkg::IdxW-1], in_divisor);
            r_in  = st.rem;
            nq_in = {nq_in[trsi_pkg::IdxW-2:0], st.q};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= v_w[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            nq_ff <= nq_in;
            r_ff  <= r_in;
            sb_ff <= sb_w[s];
         end
      end

      assign v_w[s+1]  = valid_ff;
      assign nq_w[s+1] = nq_ff;
      assign r_w[s+1]  = r_ff;
      assign sb_w[s+1] = sb_ff;
   end

   assign out_valid = v_w[N];
   assign out_quot  = nq_w[N];
   assign out_rem   = r_w[N];
   assign out_sb    = sb_w[N];

endmodule

FILE: rtl/trsi_dim.sv
// ----------------------------------------------------------------------------
// trsi_dim
// One dimension of the mapping: divide by the output stride, reduce the
// digit by the input extent, scale by the input stride and accumulate.
// ----------------------------------------------------------------------------
module trsi_dim (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       active,
   input  logic [trsi_pkg::IdxW-1:0]  out_stride,
   input  logic [trsi_pkg::IdxW-1:0]  in_stride,
   input  logic [trsi_pkg::ExtW-1:0]  extent,
   input  logic                       in_valid,
   input  logic [trsi_pkg::IdxW-1:0]  in_rem,
   input  logic [trsi_pkg::IdxW-1:0]  in_src,
   input  logic                       in_bad,
   output logic                       out_valid,
   output logic [trsi_pkg::IdxW-1:0]  out_rem,
   output logic [trsi_pkg::IdxW-1:0]  out_src,
   output logic                       out_bad
);

   localparam int W   = trsi_pkg::IdxW;
   localparam int SBW = 2 * W + 1;

   logic           d1_valid;
   logic [W-1:0]   d1_quot, d1_rem;
   logic [SBW-1:0] d1_sb;
   logic [W-1:0]   rem_sel;
   logic           d2_valid;
   logic [W-1:0]   d2_quot, d2_rem;
   logic [SBW-1:0] d2_sb;

   trsi_divider #(.SB_W(SBW)) u_stride_div (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (in_valid),
      .in_dividend (in_rem),
      .in_divisor  (out_stride),
      .in_sb       ({in_rem, in_src, in_bad}),
      .out_valid   (d1_valid),
      .out_quot    (d1_quot),
      .out_rem     (d1_rem),
      .out_sb      (d1_sb)
   );

   // An unused dimension leaves the remaining index untouched.
   assign rem_sel = active ? d1_rem : d1_sb[SBW-1 -: W];

   trsi_divider #(.SB_W(SBW)) u_extent_mod (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (d1_valid),
      .in_dividend (d1_quot),
      .in_divisor  ({{(W-trsi_pkg::ExtW){1'b0}}, extent}),
      .in_sb       ({rem_sel, d1_sb[W:0]}),
      .out_valid   (d2_valid),
      .out_quot    (d2_quot),
      .out_rem     (d2_rem),
      .out_sb      (d2_sb)
   );

   logic           mul_valid_ff;
   logic [W-1:0]   mul_prod_ff, mul_prod_in;
   logic [SBW-1:0] mul_sb_ff;
   logic           add_valid_ff;
   logic [W-1:0]   add_src_ff, add_src_in;
   logic [W-1:0]   add_rem_ff;
   logic           add_bad_ff;
   logic [W+trsi_pkg::ExtW-1:0] prod_full;

   // The reduced digit is below the extent, so 16 bits carry it.
   assign prod_full   = d2_rem[trsi_pkg::ExtW-1:0] * in_stride;
   assign mul_prod_in = (active && !d2_quot[0]) || active ? prod_full[W-1:0] : '0;
   assign add_src_in  = mul_sb_ff[W:1] + mul_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         add_valid_ff <= 1'b0;
      end else if (en) begin
         mul_valid_ff <= d2_valid;
         add_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mul_prod_ff <= mul_prod_in;
         mul_sb_ff   <= d2_sb;
         add_src_ff  <= add_src_in;
         add_rem_ff  <= mul_sb_ff[SBW-1 -: W];
         add_bad_ff  <= mul_sb_ff[0];
      end
   end

   assign out_valid = add_valid_ff;
   assign out_rem   = add_rem_ff;
   assign out_src   = add_src_ff;
   assign out_bad   = add_bad_ff;

endmodule

FILE: rtl/tile_repeat_source_index.sv
// Pipeline: a dimension unit per active-capable dimension (MAX_DIMS of them)
// plus one output register. Throughput: one beat per cycle unless a stalled
// response holds the pipeline; each stride division and extent reduction is a
// 16-stage divider retiring two bits per stage.
// Reset clears all valid bits and loads the documented register defaults.
// ----------------------------------------------------------------------------
// tile_repeat_source_index
// Maps a linear output element index of a tiled tensor to the linear index
// of the source element, with one dimension unit for each of MAX_DIMS dimensions.
// ----------------------------------------------------------------------------
module tile_repeat_source_index #(
   parameter int MAX_DIMS = trsi_pkg::MAX_DIMS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [trsi_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [trsi_pkg::CfgW-1:0]     csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [trsi_pkg::IdxW-1:0]     req_out_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [trsi_pkg::IdxW-1:0]     rsp_src_index,
   output logic                          rsp_bad_config
);

   localparam int W = trsi_pkg::IdxW;

   logic [trsi_pkg::DimsW-1:0] active_dims_ff;
   logic [trsi_pkg::CfgW-1:0]  stride_ff [MAX_DIMS];
   logic [trsi_pkg::CfgW-1:0]  extents_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_dims_ff <= trsi_pkg::ActiveDimsReset;
         for (int d = 0; d < MAX_DIMS; d++) stride_ff[d] <= trsi_pkg::StrideReset;
         extents_ff <= trsi_pkg::ExtentsReset;
      end else if (csr_write) begin
         unique case (csr_index)
            trsi_pkg::CsrActiveDims: begin
               active_dims_ff <= csr_wdata[trsi_pkg::DimsW-1:0];
            end
            trsi_pkg::CsrStride0, trsi_pkg::CsrStride1,
            trsi_pkg::CsrStride2, trsi_pkg::CsrStride3: begin
               for (int d = 0; d < MAX_DIMS; d++) begin
                  if (csr_index == trsi_pkg::CsrStride0 + 3'(d)) stride_ff[d] <= csr_wdata;
               end
            end
            trsi_pkg::CsrExtents: begin
               extents_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   logic en;
   logic rsp_valid_ff;
   logic [W-1:0] rsp_src_ff, rsp_src_in;
   logic rsp_bad_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // Dimension count above the build limit saturates.
   logic [trsi_pkg::DimsW-1:0] n_dims;
   assign n_dims = (active_dims_ff > trsi_pkg::DimsW'(MAX_DIMS))
                   ? trsi_pkg::DimsW'(MAX_DIMS) : active_dims_ff;

   logic [MAX_DIMS-1:0] dim_active;
   logic                bad_cfg;

   always_comb begin
      bad_cfg = 1'b0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         dim_active[d] = trsi_pkg::DimsW'(d) < n_dims;
         if (dim_active[d] &&
             (stride_ff[d][2*W-1:W] == '0 ||
              extents_ff[trsi_pkg::ExtW*d +: trsi_pkg::ExtW] == '0)) begin
            bad_cfg = 1'b1;
         end
      end
   end

   logic         v_w   [MAX_DIMS+1];
   logic [W-1:0] rem_w [MAX_DIMS+1];
   logic [W-1:0] src_w [MAX_DIMS+1];
   logic         bad_w [MAX_DIMS+1];

   assign v_w[0]   = req_valid;
   assign rem_w[0] = req_out_index;
   assign src_w[0] = '0;
   assign bad_w[0] = bad_cfg;

   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
      trsi_dim u_dim (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .active     (dim_active[d]),
         .out_stride (stride_ff[d][2*W-1:W]),
         .in_stride  (stride_ff[d][W-1:0]),
         .extent     (extents_ff[trsi_pkg::ExtW*d +: trsi_pkg::ExtW]),
         .in_valid   (v_w[d]),
         .in_rem     (rem_w[d]),
         .in_src     (src_w[d]),
         .in_bad     (bad_w[d]),
         .out_valid  (v_w[d+1]),
         .out_rem    (rem_w[d+1]),
         .out_src    (src_w[d+1]),
         .out_bad    (bad_w[d+1])
      );
   end

   assign rsp_src_in = bad_w[MAX_DIMS] ? '0 : src_w[MAX_DIMS];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v_w[MAX_DIMS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_src_ff <= rsp_src_in;
         rsp_bad_ff <= bad_w[MAX_DIMS];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_src_index  = rsp_src_ff;
   assign rsp_bad_config = rsp_bad_ff;

endmodule

FILE: test/tb_tile_repeat_source_index.sv
// ----------------------------------------------------------------------------
// Testbench for tile_repeat_source_index
// Feeds output element indexes under several dimension, stride and extent
// settings, with random idle and stall on both channels. Each result beat is
// checked against a behavioral source index calculation held in the bench.
// ----------------------------------------------------------------------------
module tb_tile_repeat_source_index;

   localparam int LATENCY   = 140;
   localparam int WDOG_MAX  = 20000;

   // Register indexes past the end of the register list.
   localparam logic [trsi_pkg::CsrIdxW-1:0] CsrUnmappedA = 3'd6;
   localparam logic [trsi_pkg::CsrIdxW-1:0] CsrUnmappedB = 3'd7;

   logic                          clock;
   logic                          reset;
   logic                          csr_write;
   logic [trsi_pkg::CsrIdxW-1:0]  csr_index;
   logic [trsi_pkg::CfgW-1:0]     csr_wdata;
   logic                          req_valid;
   logic                          req_stall;
   logic [trsi_pkg::IdxW-1:0]     req_out_index;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [trsi_pkg::IdxW-1:0]     rsp_src_index;
   logic                          rsp_bad_config;

   // Bench copy of the configuration.
   logic [trsi_pkg::DimsW-1:0]    cur_dims;
   logic [trsi_pkg::CfgW-1:0]     cur_stride [trsi_pkg::MAX_DIMS];
   logic [trsi_pkg::CfgW-1:0]     cur_extents;

   logic [trsi_pkg::IdxW-1:0]     exp_src_q [$];
   logic                          exp_bad_q [$];

   int  errors;
   int  items_sent;
   int  beats_checked;
   int  bad_seen;
   int  idle_cycles;
   bit  rsp_hold;
   bit  no_idle;

   tile_repeat_source_index dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_out_index  (req_out_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_src_index  (rsp_src_index),
      .rsp_bad_config (rsp_bad_config)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Source index of one output index under the current configuration.
   task automatic map_index(input logic [trsi_pkg::IdxW-1:0] idx,
                            output logic [trsi_pkg::IdxW-1:0] src, output logic bad);
      int unsigned n;
      logic [trsi_pkg::IdxW-1:0] rem, so, si, ext, digit;
      n   = (cur_dims > trsi_pkg::MAX_DIMS) ? trsi_pkg::MAX_DIMS : cur_dims;
      rem = idx;
      src = '0;
      bad = 1'b0;
      for (int d = 0; d < n; d++) begin
         if (cur_stride[d][63:32] == 0 || cur_extents[16*d +: 16] == 0)
            bad = 1'b1;
      end
      if (!bad) begin
         for (int d = 0; d < n; d++) begin
            so    = cur_stride[d][63:32];
            si    = cur_stride[d][31:0];
            ext   = {16'd0, cur_extents[16*d +: 16]};
            digit = rem / so;
            src   = src + (digit % ext) * si;
            rem   = rem % so;
         end
      end else begin
         src = '0;
      end
   endtask

   // Called at a falling edge; drops any beat still offered first.
   task automatic write_reg(input logic [trsi_pkg::CsrIdxW-1:0] idx,
                            input logic [trsi_pkg::CfgW-1:0] val);
      req_valid <= 1'b0;
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         trsi_pkg::CsrActiveDims: cur_dims = val[trsi_pkg::DimsW-1:0];
         trsi_pkg::CsrStride0:    cur_stride[0] = val;
         trsi_pkg::CsrStride1:    cur_stride[1] = val;
         trsi_pkg::CsrStride2:    cur_stride[2] = val;
         trsi_pkg::CsrStride3:    cur_stride[3] = val;
         trsi_pkg::CsrExtents:    cur_extents = val;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (exp_src_q.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   // Sends one beat; called at a falling edge, returns at a falling edge with
   // valid still high so that the next beat can follow without a gap.
   task automatic send_index(input logic [trsi_pkg::IdxW-1:0] idx);
      logic [trsi_pkg::IdxW-1:0] src;
      logic bad;
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_out_index <= idx;
      map_index(idx, src, bad);
      do @(posedge clock); while (req_stall);
      exp_src_q.push_back(src);
      exp_bad_q.push_back(bad);
      items_sent++;
      @(negedge clock);
   endtask

   // Set up a well-formed tiling: dims of random extent, row-major strides.
   task automatic config_tiling(input int n);
      logic [31:0] ostr [trsi_pkg::MAX_DIMS];
      logic [31:0] istr [trsi_pkg::MAX_DIMS];
      logic [15:0] ext [trsi_pkg::MAX_DIMS];
      logic [31:0] acc_o, acc_i;
      acc_o = 1;
      acc_i = 1;
      for (int d = trsi_pkg::MAX_DIMS - 1; d >= 0; d--) begin
         ext[d]  = 16'($urandom_range(1, 7));
         ostr[d] = acc_o;
         istr[d] = ($urandom_range(0, 5) == 0) ? 32'd0 : acc_i;
         acc_i   = acc_i * ext[d];
         acc_o   = acc_o * (ext[d] * $urandom_range(1, 3));
      end
      write_reg(trsi_pkg::CsrActiveDims, 64'(n[trsi_pkg::DimsW-1:0]));
      for (int d = 0; d < trsi_pkg::MAX_DIMS; d++)
         write_reg(trsi_pkg::CsrStride0 + d[trsi_pkg::CsrIdxW-1:0], {ostr[d], istr[d]});
      write_reg(trsi_pkg::CsrExtents, {ext[3], ext[2], ext[1], ext[0]});
   endtask

   task automatic test_reset_defaults();
      send_index(32'd0);
      send_index(32'hFFFF_FFFF);
      send_index(32'h8000_0001);
      wait_drained();
   endtask

   task automatic test_directed_corners();
      // Full-range strides and extents; products wrap.
      write_reg(trsi_pkg::CsrActiveDims, 64'd4);
      write_reg(trsi_pkg::CsrStride0, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(trsi_pkg::CsrStride1, 64'h0001_0000_8000_0001);
      write_reg(trsi_pkg::CsrStride2, 64'h0000_0100_7FFF_FFFF);
      write_reg(trsi_pkg::CsrStride3, 64'h0000_0001_0000_0003);
      write_reg(trsi_pkg::CsrExtents, 64'hFFFF_0003_8000_FFFF);
      send_index(32'hFFFF_FFFF);
      send_index(32'h0000_0000);
      send_index(32'h5555_AAAA);
      send_index(32'hAAAA_5555);
      wait_drained();
      // Dimension count above the maximum saturates.
      write_reg(trsi_pkg::CsrActiveDims, 64'd7);
      send_index(32'h1234_5678);
      send_index(32'hFFFF_FFFF);
      wait_drained();
      // No dimensions.
      write_reg(trsi_pkg::CsrActiveDims, 64'd0);
      send_index(32'hDEAD_BEEF);
      wait_drained();
      // Zero output stride in an active dimension.
      write_reg(trsi_pkg::CsrActiveDims, 64'd2);
      write_reg(trsi_pkg::CsrStride1, 64'h0000_0000_0000_0005);
      send_index(32'd77);
      wait_drained();
      // Zero extent, then the same zero only in an inactive dimension.
      write_reg(trsi_pkg::CsrStride1, 64'h0000_0010_0000_0005);
      write_reg(trsi_pkg::CsrExtents, 64'h0000_0003_0000_0005);
      send_index(32'd1000);
      wait_drained();
      write_reg(trsi_pkg::CsrActiveDims, 64'd1);
      send_index(32'd1000);
      wait_drained();
      write_reg(trsi_pkg::CsrExtents, 64'h0000_0003_0001_0005);
      write_reg(trsi_pkg::CsrActiveDims, 64'd3);
      send_index(32'd1000);
      wait_drained();
      write_reg(trsi_pkg::CsrActiveDims, 64'd4);
      send_index(32'd1000);
      wait_drained();
      // Register index beyond the list is ignored.
      write_reg(CsrUnmappedA, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CsrUnmappedB, 64'h0);
      send_index(32'd123);
      wait_drained();
   endtask

   task automatic test_random_tilings();
      int n;
      logic [31:0] span;
      for (int phase = 0; phase < 30; phase++) begin
         n = $urandom_range(0, 7);
         config_tiling(n);
         if (phase % 7 == 3) begin
            // Noise in one register, sometimes breaking the setup.
            write_reg(3'($urandom_range(0, 5)), {$urandom, $urandom});
         end
         no_idle = (phase % 5 == 1);
         span = cur_stride[0][63:32] * {16'd0, cur_extents[15:0]} * 2;
         for (int i = 0; i < 50; i++) begin
            if ($urandom_range(0, 9) == 0 || span == 0)
               send_index($urandom);
            else
               send_index($urandom_range(0, span - 1));
         end
         no_idle = 1'b0;
         wait_drained();
      end
   endtask

   task automatic test_backpressure();
      config_tiling(4);
      rsp_hold = 1'b1;
      no_idle  = 1'b1;
      for (int i = 0; i < 200; i++) send_index($urandom);
      no_idle = 1'b0;
      wait_drained();
      // Sender pauses until all results are in, then resumes.
      for (int i = 0; i < 50; i++) send_index($urandom_range(0, 500));
      wait_drained();
      for (int i = 0; i < 50; i++) send_index($urandom_range(0, 500));
      wait_drained();
   endtask

   // Receiver stall: random per beat, with a long hold-off when requested.
   initial begin
      int wait_n;
      int held;
      rsp_stall = 1'b1;
      @(negedge clock);
      forever begin
         if (rsp_hold) begin
            held = 0;
            rsp_stall <= 1'b1;
            while (held < 400) begin
               @(negedge clock);
               held++;
            end
            rsp_hold = 1'b0;
         end
         wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         if (no_idle) wait_n = 0;
         if (wait_n > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   // Result checker and idle watchdog.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (exp_src_q.size() == 0) begin
               $error("result beat with nothing expected: src_index %h", rsp_src_index);
               errors++;
            end else begin
               if (rsp_src_index !== exp_src_q[0]) begin
                  $error("src_index expected %h actual %h", exp_src_q[0], rsp_src_index);
                  errors++;
               end
               if (rsp_bad_config !== exp_bad_q[0]) begin
                  $error("bad_config expected %b actual %b", exp_bad_q[0], rsp_bad_config);
                  errors++;
               end
               if (exp_bad_q[0]) bad_seen++;
               void'(exp_src_q.pop_front());
               void'(exp_bad_q.pop_front());
               beats_checked++;
            end
         end
         if (idle_cycles >= WDOG_MAX) begin
            $display("Timeout: no beat moved for %0d cycles", WDOG_MAX);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      errors        = 0;
      items_sent    = 0;
      beats_checked = 0;
      bad_seen      = 0;
      rsp_hold      = 1'b0;
      no_idle       = 1'b0;
      reset         = 1'b1;
      csr_write     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      req_valid     = 1'b0;
      req_out_index = '0;
      cur_dims      = trsi_pkg::ActiveDimsReset;
      for (int d = 0; d < trsi_pkg::MAX_DIMS; d++) cur_stride[d] = trsi_pkg::StrideReset;
      cur_extents   = trsi_pkg::ExtentsReset;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_directed_corners();
      test_random_tilings();
      test_backpressure();

      $display("Sent %0d indexes over many tilings; checked %0d result beats,", items_sent,
               beats_checked);
      $display("%0d of them flagged as bad configuration.", bad_seen);
      if (errors == 0 && exp_src_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         if (exp_src_q.size() != 0) $error("%0d results never arrived", exp_src_q.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
